FILE: sv/aip_pkg.sv
// Shared types, character codes and digit decoding for the ASCII integer parser.
package aip_pkg;

  localparam int CHAR_BITS   = 8;
  localparam int NUMBER_BITS = 64;
  localparam int DIGIT_BITS  = 5;

  localparam logic [CHAR_BITS-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_0    = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_9    = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UA   = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UF   = 8'h46;
  localparam logic [CHAR_BITS-1:0] CH_UX   = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_LA   = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LF   = 8'h66;
  localparam logic [CHAR_BITS-1:0] CH_LX   = 8'h78;

  localparam logic [DIGIT_BITS-1:0] NO_DIGIT   = 5'h1f;
  localparam logic [DIGIT_BITS-1:0] LETTER_OFS = 5'd10;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_HEXPFX = 3'd2,
    PH_DEC    = 3'd3,
    PH_HEX    = 3'd4,
    PH_ERR    = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t phase_next;
    logic   emit;
    logic   is_valid;
  } step_ctl_t;

  // Digit value of a character, or NO_DIGIT when it is not a digit of the base.
  function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c,
                                                     input logic hex);
    logic [DIGIT_BITS-1:0] d;
    begin
      d = NO_DIGIT;
      if (c >= CH_0 && c <= CH_9) begin
        d = DIGIT_BITS'(c - CH_0);
      end else if (hex && c >= CH_LA && c <= CH_LF) begin
        d = DIGIT_BITS'(c - CH_LA) + LETTER_OFS;
      end else if (hex && c >= CH_UA && c <= CH_UF) begin
        d = DIGIT_BITS'(c - CH_UA) + LETTER_OFS;
      end
      return d;
    end
  endfunction

endpackage

FILE: sv/aip_step.sv
// Per-character next-state logic: phase transition, multiply-add and overflow check.
module aip_step #(
  parameter int VALUE_BITS = 64
) (
  input  aip_pkg::phase_t                phase,
  input  logic [VALUE_BITS-1:0]          acc,
  input  logic [aip_pkg::CHAR_BITS-1:0]  char_code,
  output logic [VALUE_BITS-1:0]          acc_next,
  output aip_pkg::step_ctl_t             ctl
);
  import aip_pkg::*;

  localparam int EXT_BITS = VALUE_BITS + 4;

  logic                  use_hex;
  logic [VALUE_BITS-1:0] acc_src;
  logic [DIGIT_BITS-1:0] digit;
  logic [EXT_BITS-1:0]   acc_ext;
  logic [EXT_BITS-1:0]   scaled;
  logic [EXT_BITS-1:0]   sum;
  logic                  digit_bad;
  phase_t                ok_phase;
  phase_t                ph;

  always_comb begin
    use_hex = (phase == PH_HEXPFX) || (phase == PH_HEX);
    acc_src = ((phase == PH_START) || (phase == PH_ZERO) || (phase == PH_HEXPFX)) ?
              '0 : acc;
    digit   = digit_of(char_code, use_hex);
    acc_ext = EXT_BITS'(acc_src);
    // x16 is a shift, x10 is x8 + x2
    scaled  = use_hex ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1));
    sum     = scaled + EXT_BITS'(digit);
    digit_bad = (digit == NO_DIGIT) || (sum[EXT_BITS-1:VALUE_BITS] != '0);
    ok_phase  = use_hex ? PH_HEX : PH_DEC;
  end

  always_comb begin
    ctl.emit     = 1'b0;
    ctl.is_valid = 1'b0;
    ph           = PH_ERR;
    acc_next     = '0;
    if (char_code == CH_NUL) begin
      ctl.emit     = 1'b1;
      ctl.is_valid = (phase == PH_ZERO) || (phase == PH_DEC) || (phase == PH_HEX);
      ph           = PH_START;
    end else begin
      case (phase)
        PH_ZERO: begin
          if (char_code == CH_LX || char_code == CH_UX) begin
            ph = PH_HEXPFX;
          end else begin
            ph = digit_bad ? PH_ERR : ok_phase;
          end
        end
        PH_HEXPFX, PH_HEX, PH_DEC: begin
          ph = digit_bad ? PH_ERR : ok_phase;
        end
        PH_ERR: begin
          ph = PH_ERR;
        end
        default: begin
          // start of token, and any code that is not a phase
          if (char_code == CH_0) begin
            ph = PH_ZERO;
          end else begin
            ph = digit_bad ? PH_ERR : ok_phase;
          end
        end
      endcase
      if (ph == PH_DEC || ph == PH_HEX) begin
        acc_next = sum[VALUE_BITS-1:0];
      end
    end
    ctl.phase_next = ph;
  end

endmodule

FILE: sv/ascii_integer_parser.sv
// Top level of the streaming ASCII unsigned-integer parser.
//
//  channel  | dir | tdata (low bit up)     | tuser        | note
//  ---------+-----+------------------------+--------------+------------------------------
//  s_axis   | in  | [7:0] char_code        | -            | one character per item
//  m_axis   | out | [63:0] number          | [0] is_valid | one item per zero terminator
//
//  An input item is taken into an input register, then combinational logic (digit
//  decode, multiply-add by 10 or 16, overflow check) updates phase and accumulator.
//  Throughput is one character per cycle while no terminator waits for the result register.
//  A terminator passes through the input register, then the result register, to be shown.
//  rst (synchronous, active high) returns to the start of a token and empties both
//  registers. A stalled output holds back only terminators; other characters continue.
module ascii_integer_parser #(
  parameter int VALUE_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // slave side
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [aip_pkg::CHAR_BITS-1:0]   s_tdata,   // [7:0] char_code
  // master side
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [aip_pkg::NUMBER_BITS-1:0] m_tdata,   // [63:0] number
  output logic                            m_tuser    // [0] is_valid
);
  import aip_pkg::*;

  // input register
  logic                  in_valid;
  logic [CHAR_BITS-1:0]  in_char;

  // parser state
  phase_t                phase;
  logic [VALUE_BITS-1:0] acc;

  logic [VALUE_BITS-1:0] acc_next;
  step_ctl_t             ctl;
  logic                  fire;

  aip_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .phase     (phase),
    .acc       (acc),
    .char_code (in_char),
    .acc_next  (acc_next),
    .ctl       (ctl)
  );

  // Advance the held character unless it is a terminator and the result slot is full and not being taken.
  assign fire     = in_valid && (!ctl.emit || !m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      acc   <= '0;
    end else if (fire) begin
      phase <= ctl.phase_next;
      acc   <= acc_next;
    end
  end

  // Result register: load on a terminator, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && ctl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctl.emit) begin
      m_tdata <= ctl.is_valid ? NUMBER_BITS'(acc) : '0;
      m_tuser <= ctl.is_valid;
    end
  end

  // An invalid result always carries zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("invalid result with nonzero number");

  // The accumulator is clear at the start of a token and after an error.
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_START || phase == PH_ERR) |-> acc == '0)
    else $error("accumulator not clear in start or error phase");

  // A terminator that fires shows a result in the next cycle.
  a_emit_shown: assert property (@(posedge clk) disable iff (rst)
    fire && ctl.emit |=> m_tvalid)
    else $error("terminator did not produce a result");

  // A held character that cannot advance stays in the input register.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(in_char))
    else $error("stalled character lost");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the streaming ASCII unsigned-integer parser.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import aip_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          ITEM_TARGET  = 1750;
  localparam int          DRAIN_CYCLES = 8;   // margin after the last expected result
  localparam int          MODE_TOKENS  = 40;  // tokens between changes of idling mode
  localparam int          MAX_IDLE     = 4;
  localparam int          REPORT_CAP   = 50;
  localparam logic [63:0] DEC_BASE     = 64'd10;
  localparam logic [63:0] HEX_BASE     = 64'd16;
  localparam logic [63:0] VALUE_MAX    = {NUMBER_BITS{1'b1}};
  localparam int          DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [NUMBER_BITS-1:0] number;
    logic                   is_valid;
  } parse_result_t;

  // One row of the directed part; typed rows carry their own expected result.
  typedef struct {
    logic [CHAR_BITS-1:0]   ch;
    bit                     typed;
    logic [NUMBER_BITS-1:0] number;
    logic                   is_valid;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [CHAR_BITS-1:0]   s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [NUMBER_BITS-1:0] m_tdata;
  logic                   m_tuser;

  // Predictor state: token phase and running value
  phase_t                 parse_phase = PH_START;
  logic [NUMBER_BITS-1:0] parse_acc = '0;

  parse_result_t expected_results[$];

  int error_count   = 0;
  int chars_sent    = 0;
  int tokens_sent   = 0;
  int results_seen  = 0;
  int valid_seen    = 0;
  int cycle_count   = 0;
  int sender_gap    = MAX_IDLE;
  int receiver_gap  = MAX_IDLE;

  directed_row_t directed[DIRECTED_ROWS] = '{
    // empty token
    '{CH_NUL, 1'b1, 64'd0, 1'b0},
    // lone zero
    '{"0",    1'b0, 64'd0, 1'b0},
    '{CH_NUL, 1'b1, 64'd0, 1'b1},
    // bare prefixes, both letter cases
    '{"0",    1'b0, 64'd0, 1'b0},
    '{CH_LX,  1'b0, 64'd0, 1'b0},
    '{CH_NUL, 1'b1, 64'd0, 1'b0},
    '{"0",    1'b0, 64'd0, 1'b0},
    '{CH_UX,  1'b0, 64'd0, 1'b0},
    '{CH_NUL, 1'b1, 64'd0, 1'b0},
    // x that does not follow a leading zero
    '{"7",    1'b0, 64'd0, 1'b0},
    '{CH_LX,  1'b0, 64'd0, 1'b0},
    '{CH_NUL, 1'b1, 64'd0, 1'b0},
    // highest character code is not a digit
    '{8'hff,  1'b0, 64'd0, 1'b0},
    '{CH_NUL, 1'b1, 64'd0, 1'b0},
    // single decimal digit
    '{"9",    1'b0, 64'd0, 1'b0},
    '{CH_NUL, 1'b1, 64'd9, 1'b1},
    // hex with mixed-case digits
    '{"0",    1'b0, 64'd0, 1'b0},
    '{CH_UX,  1'b0, 64'd0, 1'b0},
    '{"a",    1'b0, 64'd0, 1'b0},
    '{"F",    1'b0, 64'd0, 1'b0},
    '{CH_NUL, 1'b0, 64'd0, 1'b0},
    // decimal with leading zeros
    '{"0",    1'b0, 64'd0, 1'b0},
    '{"0",    1'b0, 64'd0, 1'b0},
    '{"5",    1'b0, 64'd0, 1'b0},
    '{CH_NUL, 1'b0, 64'd0, 1'b0}
  };

  ascii_integer_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] char_code
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [63:0] number
    .m_tuser  (m_tuser)    // [0] is_valid
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the handshakes hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_results.size());
      $display("ascii_integer_parser verification failed");
      $finish;
    end
  end

  // Digit value in the given base, NO_DIGIT when the character is not one
  function automatic logic [DIGIT_BITS-1:0] digit_value(input logic [CHAR_BITS-1:0] c,
                                                        input bit hex);
    logic [DIGIT_BITS-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_0 && c <= CH_9)
      d = DIGIT_BITS'(c - CH_0);
    else if (hex && c >= CH_LA && c <= CH_LF)
      d = DIGIT_BITS'(c - CH_LA + 8'd10);
    else if (hex && c >= CH_UA && c <= CH_UF)
      d = DIGIT_BITS'(c - CH_UA + 8'd10);
    return d;
  endfunction

  // Fold one digit into the running value; overflow or a foreign character is an error
  function automatic phase_t accumulate_digit(input logic [CHAR_BITS-1:0] c,
                                              input logic [63:0] base, input phase_t ok_phase);
    logic [63:0] d;
    d = 64'(digit_value(c, base == HEX_BASE));
    if (d >= base) return PH_ERR;
    if (parse_acc > (VALUE_MAX - d) / base) return PH_ERR;
    parse_acc = parse_acc * base + d;
    return ok_phase;
  endfunction

  // Advance the predictor by one character; returns 1 when a result is due
  function automatic bit predict_char(input logic [CHAR_BITS-1:0] c,
                                      output parse_result_t res);
    phase_t ph;
    ph = parse_phase;
    res = '0;
    if (c == CH_NUL) begin
      if (ph == PH_ZERO || ph == PH_DEC || ph == PH_HEX) begin
        res.number   = parse_acc;
        res.is_valid = 1'b1;
      end
      parse_phase = PH_START;
      parse_acc   = '0;
      return 1'b1;
    end
    case (ph)
      PH_START: begin
        parse_acc = '0;
        if (c == CH_0) ph = PH_ZERO;
        else ph = accumulate_digit(c, DEC_BASE, PH_DEC);
      end
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) ph = PH_HEXPFX;
        else ph = accumulate_digit(c, DEC_BASE, PH_DEC);
      end
      PH_HEXPFX, PH_HEX: ph = accumulate_digit(c, HEX_BASE, PH_HEX);
      PH_DEC:            ph = accumulate_digit(c, DEC_BASE, PH_DEC);
      default:           ph = PH_ERR;
    endcase
    if (ph == PH_ERR) parse_acc = '0;
    parse_phase = ph;
    return 1'b0;
  endfunction

  // Drive one character after a random gap, hold until taken, then predict.
  // Called and returns at a falling edge.
  task automatic push_char(input logic [CHAR_BITS-1:0] c, input bit typed,
                           input logic [NUMBER_BITS-1:0] typed_number, input logic typed_valid);
    int            gap;
    parse_result_t res;
    gap = $urandom_range(0, sender_gap);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (predict_char(c, res)) begin
      if (typed) begin
        res.number   = typed_number;
        res.is_valid = typed_valid;
      end
      expected_results.push_back(res);
      tokens_sent++;
    end
    chars_sent++;
    @(negedge clk);
  endtask

  // Upper-case some hex letters at random
  function automatic string mix_case(input string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if (r[i] >= CH_LA && r[i] <= CH_LF && $urandom_range(0, 1) == 1)
        r[i] = r[i] - CH_LA + CH_UA;
    return r;
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v >> $urandom_range(0, 63);
  endfunction

  // Build one random token (without terminator); mostly well-formed numbers
  function automatic string make_token();
    string s;
    int    kind;
    int    pos;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      s = $sformatf("%0d", random_value());
      if ($urandom_range(0, 7) == 0) s = {"00", s};
    end else if (kind < 55) begin
      s = mix_case($sformatf("%0h", random_value()));
      if ($urandom_range(0, 7) == 0) s = {"0", s};
      s = {($urandom_range(0, 1) == 1) ? "0x" : "0X", s};
    end else if (kind < 62) begin
      // decimal at the top of the range, or past it by a raised last digit or an extra digit
      s = $sformatf("%0d", VALUE_MAX);
      case ($urandom_range(0, 2))
        0: ;
        1: s[s.len()-1] = 8'(CH_0 + 8'd6 + 8'($urandom_range(0, 3)));
        default: s = {s, "0"};
      endcase
    end else if (kind < 69) begin
      // hex at the top of the range, or one digit too many
      if ($urandom_range(0, 1) == 1)
        s = {"0x", mix_case($sformatf("%016h", VALUE_MAX))};
      else
        s = {"0X", mix_case($sformatf("%0h%016h", $urandom_range(1, 15), random_value()))};
    end else if (kind < 75) begin
      s = $sformatf("%0d", $urandom_range(0, 999));
    end else if (kind < 83) begin
      // well-formed number with one character replaced by an arbitrary byte
      s = ($urandom_range(0, 1) == 1) ? $sformatf("%0d", random_value())
                                      : {"0x", $sformatf("%0h", random_value())};
      pos = $urandom_range(0, s.len() - 1);
      s[pos] = 8'($urandom_range(1, 255));
    end else if (kind < 88) begin
      // stray x anywhere in or around a decimal number, which may also get a hex prefix
      s = $sformatf("%0d", random_value());
      pos = $urandom_range(0, s.len());
      s = {s.substr(0, pos - 1), ($urandom_range(0, 1) == 1) ? "x" : "X",
           s.substr(pos, s.len() - 1)};
      if ($urandom_range(0, 1) == 1) s = {"0x", s};
    end else if (kind < 95) begin
      s = "";
      repeat ($urandom_range(1, 8)) s = {s, " "};
      for (int i = 0; i < s.len(); i++) s[i] = 8'($urandom_range(1, 255));
    end else begin
      case ($urandom_range(0, 2))
        0: s = "";
        1: s = "0x";
        default: s = "0X";
      endcase
    end
    return s;
  endfunction

  // Compare each result taken from the block with the oldest expectation
  always @(posedge clk) begin
    parse_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_CAP)
          $display("%0t: unexpected result: expected none, got number %h is_valid %b",
                   $time, m_tdata, m_tuser);
      end else begin
        exp_res = expected_results.pop_front();
        if (exp_res.is_valid) valid_seen++;
        if (m_tdata !== exp_res.number) begin
          error_count++;
          if (error_count <= REPORT_CAP)
            $display("%0t: number mismatch: expected %h, got %h",
                     $time, exp_res.number, m_tdata);
        end
        if (m_tuser !== exp_res.is_valid) begin
          error_count++;
          if (error_count <= REPORT_CAP)
            $display("%0t: is_valid mismatch: expected %b, got %b",
                     $time, exp_res.is_valid, m_tuser);
        end
      end
    end
  end

  // Result side: stall a random number of cycles before each item
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, receiver_gap);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus: reset, directed rows, then random tokens
  initial begin
    string tok;
    int    mode;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i])
      push_char(directed[i].ch, directed[i].typed, directed[i].number, directed[i].is_valid);

    while (chars_sent < ITEM_TARGET) begin
      // change idling mode now and then, so that stretches run without gaps too
      if (tokens_sent % MODE_TOKENS == 0) begin
        mode = $urandom_range(0, 3);
        sender_gap   = (mode == 1 || mode == 3) ? 0 : MAX_IDLE;
        receiver_gap = (mode == 2 || mode == 3) ? 0 : MAX_IDLE;
      end
      tok = make_token();
      for (int i = 0; i < tok.len(); i++)
        push_char(tok[i], 1'b0, '0, 1'b0);
      push_char(CH_NUL, 1'b0, '0, 1'b0);
    end
    s_tvalid <= 1'b0;

    // drain: hold until every expected result has come, then a few more cycles
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d characters in %0d tokens; checked %0d results, %0d of them valid",
             chars_sent, tokens_sent, results_seen, valid_seen);
    $display("%0d mismatches found", error_count);
    if (error_count == 0)
      $display("ascii_integer_parser verification clean");
    else
      $display("ascii_integer_parser verification failed");
    $finish;
  end

endmodule
